// ===== rtl/lbr_pkg.sv =====
// Shared types, codes and constants of the letterbox bilinear resampler.
package lbr_pkg;

    localparam int SZ_W  = 13;          // sizes up to 4096
    localparam int DIV_W = 32;          // dividend and quotient width
    localparam int DVS_W = SZ_W + 1;    // divisor width, 2*n up to 8192

    localparam int DEF_MAX_SRC_W = 640;
    localparam int DEF_MAX_SRC_H = 480;
    localparam int DEF_MAX_TGT   = 640;

    localparam logic [15:0] PAD_CODE  = 16'd14649;
    localparam logic [15:0] FULL_CODE = 16'd32768;

    typedef enum logic [1:0] {
        REG_SRC_W = 2'd0,
        REG_SRC_H = 2'd1,
        REG_TGT_W = 2'd2,
        REG_TGT_H = 2'd3
    } reg_idx_t;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REGION_PAD     = 2'd0,
        REGION_IMAGE   = 2'd1,
        REGION_OUTSIDE = 2'd2
    } region_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCALE,
        ST_RSZ_W,
        ST_RSZ_W_WAIT,
        ST_RSZ_H,
        ST_RSZ_H_WAIT,
        ST_CLASS,
        ST_LOC,
        ST_FLOOR_WAIT,
        ST_WEIGHT_WAIT,
        ST_RD00,
        ST_RD01,
        ST_RD10,
        ST_RD11,
        ST_MIX,
        ST_MIX_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [DVS_W-1:0]  remainder;
    } div_rsp_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

endpackage

// ===== rtl/letterbox_bilinear_resampler.sv =====
// Letterbox bilinear resampler: frame store, geometry sequencer and output stage.
//
// Input requests (s_*): tuser carries the operation. A load writes one source
// pixel into the frame store in the cycle it is taken and gives no result;
// loads outside the configured source size are dropped. A sample gives one
// result on m_*: the column, row, three Q1.15 values and the region code.
// Samples outside the target or in the padding skip the divider. Image
// samples take up to four 32-step divisions on the shared bit-serial
// divider (floor and weight per axis), four reads of the single-port
// frame store and a 4-stage blend pipeline.
// After reset and after every register write the scale, resized size and
// padding are derived again with two divisions; s_tready
// stays low meanwhile. Reset loads 640x480 source, 640x640 target; the frame
// store is not cleared and must be loaded before it is sampled.
// A finished result waits in the output register; while it stalls, the next
// request is still taken and processed, and only its own result waits for
// the register to free up.
module letterbox_bilinear_resampler
    import lbr_pkg::*;
#(
    parameter int MAX_SOURCE_WIDTH  = DEF_MAX_SRC_W,
    parameter int MAX_SOURCE_HEIGHT = DEF_MAX_SRC_H,
    parameter int MAX_TARGET_SIZE   = DEF_MAX_TGT
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // column, line, red_in, green_in, blue_in
    input  logic [0:0]  s_tuser,    // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // out_column, out_line, value_red, value_green, value_blue
    output logic [1:0]  m_tuser,    // region
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    localparam int DEPTH  = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LN_W   = 2 * SZ_W + 2;
    localparam logic [SZ_W-1:0] MAX_SW = SZ_W'(MAX_SOURCE_WIDTH);
    localparam logic [SZ_W-1:0] MAX_SH = SZ_W'(MAX_SOURCE_HEIGHT);
    localparam logic [SZ_W-1:0] MAX_TG = SZ_W'(MAX_TARGET_SIZE);

    function automatic logic [SZ_W-1:0] limit_size(input logic [SZ_W-1:0] v,
                                                   input logic [SZ_W-1:0] maxv);
        logic [SZ_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SZ_W'(1);
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

    // configuration and derived geometry
    logic [9:0]      src_w_reg;
    logic [8:0]      src_h_reg;
    logic [9:0]      tgt_w_reg;
    logic [9:0]      tgt_h_reg;
    logic            pend_reg;
    logic [SZ_W-1:0] num_reg, den_reg;
    logic [SZ_W-1:0] rsz_w_reg, rsz_h_reg, pad_l_reg, pad_t_reg;
    logic [SZ_W-1:0] sw, sh, tw, th;

    // request state
    state_t          state_reg, state_next;
    logic [9:0]      col_reg, row_reg;
    region_t         region_reg;
    logic            axis_reg;
    logic [SZ_W-1:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic [15:0]     wx_reg, wy_reg;
    pixel_t          p00_reg, p01_reg, p10_reg;
    logic [2:0][15:0] res_reg;

    // output register
    logic            m_valid_reg;
    logic [71:0]     m_data_reg;
    logic [1:0]      m_user_reg;
    logic            emit_load;

    // datapath nets
    logic [9:0]           in_col, in_row;
    pixel_t               in_pix;
    logic                 accept;
    logic [2*SZ_W-1:0]    cmp_a, cmp_b;
    logic [SZ_W-1:0]      rs_size, rs_tgt, rsz_val;
    logic [2*SZ_W-1:0]    rs_prod;
    logic [DIV_W-1:0]     rs_dividend;
    logic [SZ_W-1:0]      loc_off, loc_size;
    logic [2*SZ_W:0]      loc_prod;
    logic signed [LN_W-1:0] loc_num;
    logic                 loc_neg;
    logic [DVS_W-1:0]     two_n;
    logic [LN_W-1:0]      frac_wide;
    logic [DIV_W-1:0]     fl_src;
    logic [SZ_W-1:0]      nb_a, nb_b;
    logic                 outside, padding;

    div_req_t             div_req;
    div_rsp_t             div_rsp;
    logic                 st_we;
    logic [ADDR_W-1:0]    st_addr;
    logic [SZ_W-1:0]      st_col, st_row;
    pixel_t               st_rdata;
    logic                 ipl_start, ipl_valid;
    logic [2:0][15:0]     ipl_value;

    assign in_col = s_tdata[9:0];
    assign in_row = s_tdata[19:10];
    assign in_pix = s_tdata[43:20];
    assign accept = s_tvalid && s_tready;

    assign sw = limit_size(SZ_W'(src_w_reg), MAX_SW);
    assign sh = limit_size(SZ_W'(src_h_reg), MAX_SH);
    assign tw = limit_size(SZ_W'(tgt_w_reg), MAX_TG);
    assign th = limit_size(SZ_W'(tgt_h_reg), MAX_TG);

    assign cmp_a = tw * sh;
    assign cmp_b = th * sw;

    // resized length: (2*s*num + den) / (2*den), clamped to 1..target
    assign rs_size     = (state_reg == ST_RSZ_H || state_reg == ST_RSZ_H_WAIT) ? sh : sw;
    assign rs_tgt      = (state_reg == ST_RSZ_H || state_reg == ST_RSZ_H_WAIT) ? th : tw;
    assign rs_prod     = rs_size * num_reg;
    assign rs_dividend = DIV_W'({rs_prod, 1'b0}) + DIV_W'(den_reg);
    always_comb
    begin
        if (div_rsp.quotient == '0)
        begin
            rsz_val = SZ_W'(1);
        end
        else if (div_rsp.quotient > DIV_W'(rs_tgt))
        begin
            rsz_val = rs_tgt;
        end
        else
        begin
            rsz_val = div_rsp.quotient[SZ_W-1:0];
        end
    end

    // source coordinate numerator (2x+1)*den - num over 2*num
    assign loc_off   = axis_reg ? (SZ_W'(row_reg) - pad_t_reg) : (SZ_W'(col_reg) - pad_l_reg);
    assign loc_size  = axis_reg ? sh : sw;
    assign two_n     = {num_reg, 1'b0};
    assign loc_prod  = {loc_off, 1'b1} * den_reg;
    assign loc_num   = signed'({1'b0, loc_prod}) - signed'(LN_W'(num_reg));
    assign loc_neg   = loc_num[LN_W-1];
    // a negative numerator is never below -2n, so its floor is -1
    assign frac_wide = unsigned'(loc_num) + LN_W'(two_n);

    assign fl_src = (state_reg == ST_LOC) ? '0 : div_rsp.quotient;
    assign nb_a   = (fl_src > DIV_W'(loc_size - SZ_W'(1))) ? (loc_size - SZ_W'(1))
                                                           : fl_src[SZ_W-1:0];
    assign nb_b   = ((nb_a + SZ_W'(1)) < loc_size) ? (nb_a + SZ_W'(1))
                                                  : (loc_size - SZ_W'(1));

    assign outside = (SZ_W'(col_reg) >= tw) || (SZ_W'(row_reg) >= th);
    assign padding = (SZ_W'(col_reg) < pad_l_reg)
                  || ({1'b0, SZ_W'(col_reg)} >= ({1'b0, pad_l_reg} + {1'b0, rsz_w_reg}))
                  || (SZ_W'(row_reg) < pad_t_reg)
                  || ({1'b0, SZ_W'(row_reg)} >= ({1'b0, pad_t_reg} + {1'b0, rsz_h_reg}));

    assign emit_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pend_reg)
                begin
                    state_next = ST_SCALE;
                end
                else if (s_tvalid && s_tuser[0] == OP_SAMPLE)
                begin
                    state_next = ST_CLASS;
                end
            end
            ST_SCALE:      state_next = ST_RSZ_W;
            ST_RSZ_W:      state_next = ST_RSZ_W_WAIT;
            ST_RSZ_W_WAIT: state_next = div_rsp.done ? ST_RSZ_H : ST_RSZ_W_WAIT;
            ST_RSZ_H:      state_next = ST_RSZ_H_WAIT;
            ST_RSZ_H_WAIT: state_next = div_rsp.done ? ST_IDLE : ST_RSZ_H_WAIT;
            ST_CLASS:      state_next = (outside || padding) ? ST_EMIT : ST_LOC;
            ST_LOC:        state_next = loc_neg ? ST_WEIGHT_WAIT : ST_FLOOR_WAIT;
            ST_FLOOR_WAIT: state_next = div_rsp.done ? ST_WEIGHT_WAIT : ST_FLOOR_WAIT;
            ST_WEIGHT_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = axis_reg ? ST_RD00 : ST_LOC;
                end
            end
            ST_RD00:       state_next = ST_RD01;
            ST_RD01:       state_next = ST_RD10;
            ST_RD10:       state_next = ST_RD11;
            ST_RD11:       state_next = ST_MIX;
            ST_MIX:        state_next = ST_MIX_WAIT;
            ST_MIX_WAIT:   state_next = ipl_valid ? ST_EMIT : ST_MIX_WAIT;
            ST_EMIT:       state_next = emit_load ? ST_IDLE : ST_EMIT;
            default:       state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready         = (state_reg == ST_IDLE) && !pend_reg;
        st_we            = 1'b0;
        st_col           = SZ_W'(in_col);
        st_row           = SZ_W'(in_row);
        ipl_start        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = rs_dividend;
        div_req.divisor  = {den_reg, 1'b0};
        case (state_reg)
            ST_IDLE:
            begin
                st_we = accept && (s_tuser[0] == OP_LOAD)
                     && (SZ_W'(in_col) < sw) && (SZ_W'(in_row) < sh);
            end
            ST_RSZ_W, ST_RSZ_H:
            begin
                div_req.start = 1'b1;
            end
            ST_LOC:
            begin
                div_req.start    = 1'b1;
                div_req.divisor  = two_n;
                div_req.dividend = loc_neg ? DIV_W'({frac_wide[DVS_W-1:0], 16'd0})
                                           : DIV_W'(unsigned'(loc_num));
            end
            ST_FLOOR_WAIT:
            begin
                div_req.start    = div_rsp.done;
                div_req.divisor  = two_n;
                div_req.dividend = DIV_W'({div_rsp.remainder, 16'd0});
            end
            ST_RD00:
            begin
                st_col = x0_reg;
                st_row = y0_reg;
            end
            ST_RD01:
            begin
                st_col = x1_reg;
                st_row = y0_reg;
            end
            ST_RD10:
            begin
                st_col = x0_reg;
                st_row = y1_reg;
            end
            ST_RD11:
            begin
                st_col = x1_reg;
                st_row = y1_reg;
            end
            ST_MIX:
            begin
                ipl_start = 1'b1;
            end
            default:
            begin
            end
        endcase
        st_addr = ADDR_W'(32'(st_row) * 32'(MAX_SOURCE_WIDTH) + 32'(st_col));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            src_w_reg <= 10'd640;
            src_h_reg <= 9'd480;
            tgt_w_reg <= 10'd640;
            tgt_h_reg <= 10'd640;
            pend_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && pend_reg)
            begin
                pend_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                pend_reg <= 1'b1;
                case (cfg_index)
                    REG_SRC_W: src_w_reg <= cfg_data;
                    REG_SRC_H: src_h_reg <= cfg_data[8:0];
                    REG_TGT_W: tgt_w_reg <= cfg_data;
                    REG_TGT_H: tgt_h_reg <= cfg_data;
                    default:   pend_reg  <= 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    col_reg <= in_col;
                    row_reg <= in_row;
                end
            end
            ST_SCALE:
            begin
                if (cmp_a <= cmp_b)
                begin
                    num_reg <= tw;
                    den_reg <= sw;
                end
                else
                begin
                    num_reg <= th;
                    den_reg <= sh;
                end
            end
            ST_RSZ_W_WAIT:
            begin
                if (div_rsp.done)
                begin
                    rsz_w_reg <= rsz_val;
                    pad_l_reg <= (tw - rsz_val) >> 1;
                end
            end
            ST_RSZ_H_WAIT:
            begin
                if (div_rsp.done)
                begin
                    rsz_h_reg <= rsz_val;
                    pad_t_reg <= (th - rsz_val) >> 1;
                end
            end
            ST_CLASS:
            begin
                axis_reg <= 1'b0;
                if (outside)
                begin
                    region_reg <= REGION_OUTSIDE;
                    res_reg    <= '0;
                end
                else if (padding)
                begin
                    region_reg <= REGION_PAD;
                    res_reg    <= {PAD_CODE, PAD_CODE, PAD_CODE};
                end
                else
                begin
                    region_reg <= REGION_IMAGE;
                end
            end
            ST_LOC, ST_FLOOR_WAIT:
            begin
                if (state_reg == ST_LOC ? loc_neg : div_rsp.done)
                begin
                    if (axis_reg)
                    begin
                        y0_reg <= nb_a;
                        y1_reg <= nb_b;
                    end
                    else
                    begin
                        x0_reg <= nb_a;
                        x1_reg <= nb_b;
                    end
                end
            end
            ST_WEIGHT_WAIT:
            begin
                if (div_rsp.done)
                begin
                    axis_reg <= 1'b1;
                    if (axis_reg)
                    begin
                        wy_reg <= div_rsp.quotient[15:0];
                    end
                    else
                    begin
                        wx_reg <= div_rsp.quotient[15:0];
                    end
                end
            end
            ST_RD01: p00_reg <= st_rdata;
            ST_RD10: p01_reg <= st_rdata;
            ST_RD11: p10_reg <= st_rdata;
            ST_MIX_WAIT:
            begin
                if (ipl_valid)
                begin
                    res_reg <= ipl_value;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            m_data_reg <= {4'd0, res_reg[2], res_reg[1], res_reg[0], row_reg, col_reg};
            m_user_reg <= region_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    lbr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    lbr_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .addr  (st_addr),
        .wdata (in_pix),
        .rdata (st_rdata)
    );

    lbr_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (ipl_start),
        .p00       (p00_reg),
        .p01       (p01_reg),
        .p10       (p10_reg),
        .p11       (st_rdata),
        .wx        (wx_reg),
        .wy        (wy_reg),
        .valid_out (ipl_valid),
        .value     (ipl_value)
    );

`ifndef SYNTHESIS
    a_store_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> state_reg == ST_IDLE)
        else $error("frame store written outside idle");

    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_blend_window: assert property (@(posedge clk) disable iff (!rst_n)
        ipl_valid |-> state_reg == ST_MIX_WAIT)
        else $error("blend result outside its wait state");

    a_image_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == REGION_IMAGE) |->
            (m_tdata[35:20] <= FULL_CODE && m_tdata[51:36] <= FULL_CODE
             && m_tdata[67:52] <= FULL_CODE))
        else $error("image value above full scale");
`endif

endmodule

// ===== rtl/lbr_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module lbr_div
    import lbr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;    // dividend shifts out, quotient shifts in
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DVS_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== rtl/lbr_store.sv =====
// Single-port frame memory with registered read data.
module lbr_store
    import lbr_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_SRC_W * DEF_MAX_SRC_H,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  pixel_t            wdata,
    output pixel_t            rdata
);

    pixel_t mem [DEPTH];
    pixel_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lbr_interp.sv =====
// Four-stage bilinear blend of three colour lanes with /255 Q1.15 scaling.
module lbr_interp
    import lbr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid_in,
    input  pixel_t          p00,
    input  pixel_t          p01,
    input  pixel_t          p10,
    input  pixel_t          p11,
    input  logic [15:0]     wx,
    input  logic [15:0]     wy,
    output logic            valid_out,
    output logic [2:0][15:0] value
);

    logic [3:0]        vld_reg;
    logic [15:0]       wy_reg;
    logic [16:0]       wxc;
    logic [16:0]       wyc;
    logic [2:0][23:0]  top_reg;
    logic [2:0][23:0]  bot_reg;
    logic [2:0][39:0]  v_reg;
    logic [2:0][15:0]  q0_reg;
    logic [2:0][9:0]   r0_reg;
    logic [2:0][15:0]  val_reg;

    assign wxc = 17'd65536 - {1'b0, wx};
    assign wyc = 17'd65536 - {1'b0, wy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        wy_reg <= wy;
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        logic [7:0]  a, b, d0, d1;
        logic [39:0] u;
        logic [22:0] t;
        logic [31:0] t257;
        logic [15:0] q0;
        logic [24:0] r0;
        logic [16:0] q;

        assign a  = p00[8*c +: 8];
        assign b  = p01[8*c +: 8];
        assign d0 = p10[8*c +: 8];
        assign d1 = p11[8*c +: 8];

        assign u    = v_reg[c] + 40'd16711680;      // + 255 * 2^16
        assign t    = u[39:17];
        assign t257 = {1'b0, t, 8'd0} + {9'd0, t};
        assign q0   = t257[31:16];
        // estimate is low by at most one
        assign r0   = {2'd0, t} + {9'd0, q0} - {1'b0, q0, 8'd0};
        assign q    = {1'b0, q0_reg[c]} + ((r0_reg[c] >= 10'd255) ? 17'd1 : 17'd0);

        always_ff @(posedge clk)
        begin
            top_reg[c] <= {16'd0, a} * {7'd0, wxc} + {16'd0, b} * {8'd0, wx};
            bot_reg[c] <= {16'd0, d0} * {7'd0, wxc} + {16'd0, d1} * {8'd0, wx};
            v_reg[c]   <= {16'd0, top_reg[c]} * {23'd0, wyc}
                        + {16'd0, bot_reg[c]} * {24'd0, wy_reg};
            q0_reg[c]  <= q0;
            r0_reg[c]  <= r0[9:0];
            val_reg[c] <= (q > {1'b0, FULL_CODE}) ? FULL_CODE : q[15:0];
        end
    end

    assign valid_out = vld_reg[3];
    assign value     = val_reg;

endmodule
